// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define AMM_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define AMM_ASSERT_CLK(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== hdl/amm_pkg.sv =====
`default_nettype none
package amm_pkg;

  localparam int MAX_INPUTS     = 8;
  localparam int MAX_OUTPUTS    = 8;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int FIELD_LANES    = 8;

  localparam int CH_W    = 3;
  localparam int CNT_W   = 4;
  localparam int SMP_W   = 24;
  localparam int GAIN_W  = 16;
  localparam int PROD_W  = SMP_W + GAIN_W;
  localparam int ACC_W   = PROD_W + ((MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1);
  localparam int MIX_W   = 24;

  localparam int GT_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int GT_AW    = (GT_DEPTH > 1) ? $clog2(GT_DEPTH) : 1;
  localparam int FS_AW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - CH_W - MIX_W;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

  // op codes carried in tuser
  localparam logic OP_GAIN   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic CFG_IN_COUNT  = 1'b0;
  localparam logic CFG_OUT_COUNT = 1'b1;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  // Zero means one channel; clamp to the table size and the field reach.
  function automatic logic [CNT_W-1:0] active_count(logic [CNT_W-1:0] r, int limit);
    logic [CNT_W-1:0] n;
    n = r;
    if (n == '0) n = CNT_W'(1);
    if (int'(n) > limit) n = CNT_W'(limit);
    if (int'(n) > FIELD_LANES) n = CNT_W'(FIELD_LANES);
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/amm_ram.sv =====
`default_nettype none
module amm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/amm_mac.sv =====
`default_nettype none
module amm_mac
  import amm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire mac_ctl_t                  ctl,
  input  wire logic signed [SMP_W-1:0]   smp,
  input  wire logic signed [GAIN_W-1:0]  gain,
  output logic                           res_vld,
  output logic signed [MIX_W-1:0]        res
);

  // stage 1: product
  logic                     p_vld_r, p_first_r, p_last_r;
  logic signed [PROD_W-1:0] prod_r;
  // stage 2: accumulate
  logic                     a_done_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, prod_ext;
  // stage 3: round toward zero, saturate
  logic                     res_vld_r;
  logic signed [MIX_W-1:0]  res_r, res_nxt;
  logic signed [ACC_W-1:0]  rnd, q;
  logic                     fits;

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_nxt  = p_first_r ? prod_ext : acc_r + prod_ext;

  // negative sums get 2^F-1 added so the arithmetic shift truncates toward zero
  assign rnd  = acc_r + (acc_r[ACC_W-1] ? ACC_W'((2 ** GAIN_FRAC_BITS) - 1) : '0);
  assign q    = rnd >>> GAIN_FRAC_BITS;
  assign fits = (&q[ACC_W-1:MIX_W-1]) | ~(|q[ACC_W-1:MIX_W-1]);

  always_comb begin
    if (fits) begin
      res_nxt = q[MIX_W-1:0];
    end else if (q[ACC_W-1]) begin
      res_nxt = {1'b1, {(MIX_W-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(MIX_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      p_first_r <= 1'b0;
      p_last_r  <= 1'b0;
      a_done_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      p_vld_r   <= ctl.vld;
      p_first_r <= ctl.first;
      p_last_r  <= ctl.last;
      a_done_r  <= p_vld_r & p_last_r;
      res_vld_r <= a_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      prod_r <= PROD_W'(smp) * PROD_W'(gain);
    end
    if (p_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (a_done_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule
`default_nettype wire

// ===== hdl/audio_matrix_mixer_top.sv =====
// Channel   Dir  Handshake              Word
// in_       in   in_tvalid/in_tready    tuser op; tdata gain write or one sample
// out_      out  out_tvalid/out_tready  tdata channel, mixed; tlast on last output
// cfg_      in   cfg_we                 cfg_idx selects in_count / out_count
//
// Gain writes and non-final samples are accepted while idle. The final input channel's sample
// starts the mix: each output runs in_count terms through the single shared
// multiply-accumulate unit (RAM read, multiply, accumulate, round), one output at a
// time; the next output waits until the previous result is loaded into the output register.
// in_tready is low while mixing; a stalled result holds the sequencer until taken.
// Synchronous active-low reset clears the gain-entry valid bits, so the whole gain
// table reads as zero at once; no clearing pass is needed.
`default_nettype none
module audio_matrix_mixer_top
  import amm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // slave stream
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,   // [2:0] in_channel, [5:3] out_channel,
                                                   // [21:6] gain, [45:22] sample, pad
  input  wire logic                    in_tuser,   // [0] op
  // master stream
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata,  // [2:0] channel, [26:3] mixed, pad
  output logic                         out_tlast,
  // configuration
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_idx,
  input  wire logic [CNT_W-1:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CH_W-1:0]  o_r, o_nxt;  // output channel being mixed
  logic [CH_W-1:0]  k_r, k_nxt;  // input channel term being issued
  logic [CNT_W-1:0] in_cnt_r, out_cnt_r;
  logic [CNT_W-1:0] n_in, n_out;

  // input word fields
  logic                     in_op;
  logic [CH_W-1:0]          in_ich, in_och;
  logic signed [GAIN_W-1:0] in_gain;
  logic signed [SMP_W-1:0]  in_smp;
  logic                     in_acc;

  // frame store and gain table
  logic signed [SMP_W-1:0]  frame_r [MAX_INPUTS];
  logic [GT_DEPTH-1:0]      gv_r;
  logic                     gv_q_r;
  logic signed [SMP_W-1:0]  smp_q_r;
  logic                     gt_we;
  logic [GT_AW-1:0]         gt_waddr, gt_raddr;
  logic [GAIN_W-1:0]        gt_q;
  logic signed [GAIN_W-1:0] gain_eff;
  logic                     smp_we, frame_go;

  // sequencer to MAC
  mac_ctl_t                 ctl_r;
  logic                     issue, k_last, o_last;
  logic                     res_vld;
  logic signed [MIX_W-1:0]  res;

  // output register
  logic                     out_vld_r, out_last_r, out_load;
  logic [CH_W-1:0]          out_ch_r;
  logic signed [MIX_W-1:0]  out_mix_r;

  assign in_op   = in_tuser;
  assign in_ich  = in_tdata[2:0];
  assign in_och  = in_tdata[5:3];
  assign in_gain = in_tdata[21:6];
  assign in_smp  = in_tdata[45:22];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  assign n_in  = active_count(in_cnt_r, MAX_INPUTS);
  assign n_out = active_count(out_cnt_r, MAX_OUTPUTS);

  // gain writes outside the table are dropped
  assign gt_we    = in_acc && (in_op == OP_GAIN) &&
                    (int'(in_ich) < MAX_INPUTS) && (int'(in_och) < MAX_OUTPUTS);
  assign gt_waddr = GT_AW'(int'(in_och) * MAX_INPUTS + int'(in_ich));
  assign gt_raddr = GT_AW'(int'(o_r) * MAX_INPUTS + int'(k_r));

  assign smp_we   = in_acc && (in_op == OP_SAMPLE) && (int'(in_ich) < MAX_INPUTS);
  assign frame_go = smp_we && (CNT_W'(in_ich) == n_in - CNT_W'(1));

  assign issue  = (state_r == S_ISSUE);
  assign k_last = (CNT_W'(k_r) == n_in - CNT_W'(1));
  assign o_last = (CNT_W'(o_r) == n_out - CNT_W'(1));

  assign out_load = (state_r == S_EMIT) && (!out_vld_r || out_tready);

  // entries never written since reset read as zero
  assign gain_eff = gv_q_r ? gt_q : '0;

  amm_ram #(
    .WIDTH (GAIN_W),
    .DEPTH (GT_DEPTH)
  ) u_gain_ram (
    .clk     (clk),
    .wr_en   (gt_we),
    .wr_addr (gt_waddr),
    .wr_data (in_gain),
    .rd_addr (gt_raddr),
    .rd_data (gt_q)
  );

  amm_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_r),
    .smp     (smp_q_r),
    .gain    (gain_eff),
    .res_vld (res_vld),
    .res     (res)
  );

  always_comb begin
    state_nxt = state_r;
    o_nxt     = o_r;
    k_nxt     = k_r;
    case (state_r)
      S_IDLE: begin
        if (frame_go) begin
          state_nxt = S_ISSUE;
          o_nxt     = '0;
          k_nxt     = '0;
        end
      end
      S_ISSUE: begin
        k_nxt = k_r + CH_W'(1);
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (res_vld) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          if (o_last) begin
            state_nxt = S_IDLE;
          end else begin
            o_nxt     = o_r + CH_W'(1);
            state_nxt = S_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      o_r       <= '0;
      k_r       <= '0;
      in_cnt_r  <= CNT_RESET;
      out_cnt_r <= CNT_RESET;
      gv_r      <= '0;
      ctl_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      o_r     <= o_nxt;
      k_r     <= k_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_IN_COUNT:  in_cnt_r  <= cfg_data;
          CFG_OUT_COUNT: out_cnt_r <= cfg_data;
          default: ;
        endcase
      end
      if (gt_we) begin
        gv_r[gt_waddr] <= 1'b1;
      end
      // lines up with the registered RAM and frame reads
      ctl_r <= '{vld: issue, first: (k_r == '0), last: k_last};
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_we) begin
      frame_r[FS_AW'(in_ich)] <= in_smp;
    end
    smp_q_r <= frame_r[FS_AW'(k_r)];
    gv_q_r  <= gv_r[gt_raddr];
    if (out_load) begin
      out_ch_r   <= o_r;
      out_mix_r  <= res;
      out_last_r <= o_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_mix_r, out_ch_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== hdl/amm_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module amm_checker
  import amm_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_tvalid,
  input wire logic                    in_tready,
  input wire logic [IN_TDATA_W-1:0]   in_tdata,
  input wire logic                    in_tuser,
  input wire logic                    out_tvalid,
  input wire logic                    out_tready,
  input wire logic [OUT_TDATA_W-1:0]  out_tdata,
  input wire logic                    out_tlast,
  input wire logic                    cfg_we,
  input wire logic                    cfg_idx,
  input wire logic [CNT_W-1:0]        cfg_data
);

  logic [CNT_W-1:0] in_cnt_r, out_cnt_r, n_in, n_out;
  logic [CH_W-1:0]  exp_ch_r;
  logic             frame_hit, out_acc;

  assign n_in      = active_count(in_cnt_r, MAX_INPUTS);
  assign n_out     = active_count(out_cnt_r, MAX_OUTPUTS);
  assign out_acc   = out_tvalid & out_tready;
  assign frame_hit = in_tvalid && in_tready && (in_tuser == OP_SAMPLE) &&
                     (int'(in_tdata[2:0]) < MAX_INPUTS) &&
                     (CNT_W'(in_tdata[2:0]) == n_in - CNT_W'(1));

  // mirror of the count registers and the expected output channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= CNT_RESET;
      out_cnt_r <= CNT_RESET;
      exp_ch_r  <= '0;
    end else begin
      if (cfg_we && (cfg_idx == CFG_IN_COUNT)) begin
        in_cnt_r <= cfg_data;
      end
      if (cfg_we && (cfg_idx == CFG_OUT_COUNT)) begin
        out_cnt_r <= cfg_data;
      end
      if (out_acc) begin
        exp_ch_r <= out_tlast ? '0 : exp_ch_r + CH_W'(1);
      end
    end
  end

  `AMM_ASSERT(a_frame_busy, clk, rst_n, frame_hit |=> !in_tready, "final sample did not start mix")
  `AMM_ASSERT(a_ch_order, clk, rst_n, out_tvalid |-> (out_tdata[2:0] == exp_ch_r), "output channel out of order")
  `AMM_ASSERT(a_last_ch, clk, rst_n, out_tvalid |-> (out_tlast == (CNT_W'(out_tdata[2:0]) == n_out - CNT_W'(1))), "tlast not on final output channel")
  `AMM_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)), "stalled output word changed")
  `AMM_ASSERT_CLK(a_rst_idle, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind audio_matrix_mixer_top amm_checker u_amm_checker (.*);
`default_nettype wire

// ===== tb/audio_matrix_mixer_top_test.sv =====
`default_nettype none
module audio_matrix_mixer_top_test
  import amm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Guard against a hung handshake.
  localparam int     CYCLE_LIMIT = 400000;
  // Idle cycles after the last result before touching config or ending the run;
  // covers a full 8x8 mix plus slack.
  localparam int     SETTLE      = 150;
  localparam int     LONG_HOLD   = 400;
  localparam int     IDLE_PCT    = 11;
  localparam int     PHASES      = 8;
  localparam int     PHASE_WORDS = 20;
  localparam longint MIX_TOP     = 64'sd8388607;
  localparam longint MIX_BOT     = -64'sd8388608;

  typedef struct packed {
    logic               op;
    logic [CH_W-1:0]    ich;
    logic [CH_W-1:0]    och;
    logic [GAIN_W-1:0]  gain;
    logic [SMP_W-1:0]   smp;
  } mix_word_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [MIX_W-1:0] mix;
    logic             last;
  } mix_result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    mix_word_t        w;
    logic             known;      // mixed value typed in for every output of the frame
    logic [MIX_W-1:0] known_mix;
    logic             reg_sel;
    logic [CNT_W-1:0] reg_val;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    in_tuser = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;
  logic                    cfg_we = 1'b0;
  logic                    cfg_idx = 1'b0;
  logic [CNT_W-1:0]        cfg_data = '0;

  audio_matrix_mixer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [2:0] in_channel, [5:3] out_channel, [21:6] gain,
                              // [45:22] sample, pad
    .in_tuser   (in_tuser),   // [0] op
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [2:0] channel, [26:3] mixed, pad
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  int cycle_cnt = 0;
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // ---------------------------------------------------------------------------
  // Mixer shadow: gain table, per-channel frame store, count registers
  // ---------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] gain_shadow [GT_DEPTH];
  logic signed [SMP_W-1:0]  frame_shadow [MAX_INPUTS];
  logic [CNT_W-1:0]         in_cnt_r  = CNT_RESET;
  logic [CNT_W-1:0]         out_cnt_r = CNT_RESET;

  mix_result_t mix_due_q [$];

  int  err_cnt    = 0;
  int  words_sent = 0;
  int  gain_words = 0;
  int  frames_cnt = 0;
  int  results_ok = 0;
  int  cfg_writes = 0;
  bit  no_idle    = 1'b0;   // both sides stream without gaps while set
  int  hold_left  = 0;      // receiver holds off for this many cycles

  initial begin
    foreach (gain_shadow[i]) gain_shadow[i] = '0;
    foreach (frame_shadow[i]) frame_shadow[i] = '0;
  end

  // zero counts as one lane; clipped to the table and to what 3 bits can address
  function automatic int lane_count(logic [CNT_W-1:0] r, int limit);
    int n;
    n = (r == '0) ? 1 : int'(r);
    if (n > limit) n = limit;
    if (n > 8) n = 8;
    return n;
  endfunction

  // Applies one accepted word to the shadow and queues the outputs it triggers.
  task automatic predict_mix(mix_word_t w, logic known, logic [MIX_W-1:0] known_mix);
    int          n_in;
    int          n_out;
    longint      acc;
    longint      q;
    mix_result_t r;
    if (w.op == OP_GAIN) begin
      gain_shadow[int'(w.och) * MAX_INPUTS + int'(w.ich)] = w.gain;
      gain_words++;
      return;
    end
    frame_shadow[w.ich] = w.smp;
    n_in = lane_count(in_cnt_r, MAX_INPUTS);
    if (int'(w.ich) != n_in - 1) return;
    n_out = lane_count(out_cnt_r, MAX_OUTPUTS);
    frames_cnt++;
    for (int o = 0; o < n_out; o++) begin
      acc = 0;
      for (int k = 0; k < n_in; k++)
        acc += longint'(frame_shadow[k]) * longint'(gain_shadow[o * MAX_INPUTS + k]);
      // truncate toward zero, then clip to 24 bits
      q = (acc < 0) ? -((-acc) >>> GAIN_FRAC_BITS) : (acc >>> GAIN_FRAC_BITS);
      if (q > MIX_TOP) q = MIX_TOP;
      if (q < MIX_BOT) q = MIX_BOT;
      r.ch   = CH_W'(o);
      r.mix  = known ? known_mix : q[MIX_W-1:0];
      r.last = (o == n_out - 1);
      mix_due_q.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern and checker
  // ---------------------------------------------------------------------------
  initial begin : sink
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : result_check
    mix_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (mix_due_q.size() == 0) begin
        $error("result word with nothing pending: tdata %h tlast %b", out_tdata, out_tlast);
        err_cnt++;
      end else begin
        want = mix_due_q.pop_front();
        if (out_tdata[CH_W-1:0] !== want.ch) begin
          $error("channel: expected %0d, got %0d", want.ch, out_tdata[CH_W-1:0]);
          err_cnt++;
        end
        if (out_tdata[CH_W +: MIX_W] !== want.mix) begin
          $error("mixed: expected %0d, got %0d", $signed(want.mix),
                 $signed(out_tdata[CH_W +: MIX_W]));
          err_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_tlast);
          err_cnt++;
        end
        results_ok++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offers one word, with random gaps ahead of it, and holds it until taken.
  task automatic send_word(mix_word_t w, logic known = 1'b0, logic [MIX_W-1:0] known_mix = '0);
    while (!no_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= w.op;
    in_tdata  <= {2'b00, w.smp, w.gain, w.och, w.ich};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    predict_mix(w, known, known_mix);
  endtask

  // Drops valid, then waits for every pending result plus settle time.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (mix_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    if (idx == CFG_IN_COUNT) in_cnt_r = val;
    else out_cnt_r = val;
    cfg_writes++;
  endtask

  function automatic logic [SMP_W-1:0] rand_sample();
    logic signed [SMP_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = 24'h7FFFFF;
      1:       v = 24'h800000;
      2:       v = SMP_W'($urandom_range(0, 2047)) - 24'sd1024;
      default: v = SMP_W'($urandom);
    endcase
    return v;
  endfunction

  // often within plus or minus unity so mixes don't all clip
  function automatic logic [GAIN_W-1:0] rand_gain();
    logic signed [GAIN_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2, 3, 4: v = GAIN_W'($urandom_range(0, 8191)) - 16'sd4096;
      default: v = GAIN_W'($urandom);
    endcase
    return v;
  endfunction

  // Unused fields of each word carry random bits; the block must ignore them.
  function automatic mix_word_t gain_word(int ich, int och, logic [GAIN_W-1:0] g);
    mix_word_t w;
    w.op   = OP_GAIN;
    w.ich  = CH_W'(ich);
    w.och  = CH_W'(och);
    w.gain = g;
    w.smp  = SMP_W'($urandom);
    return w;
  endfunction

  function automatic mix_word_t sample_word(int ich, logic [SMP_W-1:0] s);
    mix_word_t w;
    w.op   = OP_SAMPLE;
    w.ich  = CH_W'(ich);
    w.och  = CH_W'($urandom);
    w.gain = GAIN_W'($urandom);
    w.smp  = s;
    return w;
  endfunction

  function automatic dir_row_t gain_row(int ich, int och, logic [GAIN_W-1:0] g);
    dir_row_t r;
    r.kind  = ROW_WORD;
    r.w     = gain_word(ich, och, g);
    r.known = 1'b0;
    r.known_mix = '0;
    r.reg_sel = 1'b0;
    r.reg_val = '0;
    return r;
  endfunction

  function automatic dir_row_t smp_row(int ich, logic [SMP_W-1:0] s, logic known = 1'b0,
                                       logic [MIX_W-1:0] km = '0);
    dir_row_t r;
    r.kind  = ROW_WORD;
    r.w     = sample_word(ich, s);
    r.known = known;
    r.known_mix = km;
    r.reg_sel = 1'b0;
    r.reg_val = '0;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic idx, logic [CNT_W-1:0] v);
    dir_row_t r;
    r.kind  = ROW_CFG;
    r.w     = '0;
    r.known = 1'b0;
    r.known_mix = '0;
    r.reg_sel = idx;
    r.reg_val = v;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t dir_rows [$];
    int       in_set  [PHASES];
    int       out_set [PHASES];
    int       n_in;
    int       sent;
    int       pick;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // -- directed --
    // fresh table is all zero: any frame mixes to zero
    dir_rows.push_back(smp_row(0, 24'h7FFFFF));
    dir_rows.push_back(smp_row(1, 24'h800000, 1'b1, 24'h000000));
    // full-scale positive gains on the 2x2 corner
    dir_rows.push_back(gain_row(0, 0, 16'h7FFF));
    dir_rows.push_back(gain_row(1, 0, 16'h7FFF));
    dir_rows.push_back(gain_row(0, 1, 16'h7FFF));
    dir_rows.push_back(gain_row(1, 1, 16'h7FFF));
    // both outputs clip high, then clip low
    dir_rows.push_back(smp_row(0, 24'h7FFFFF));
    dir_rows.push_back(smp_row(1, 24'h7FFFFF, 1'b1, 24'h7FFFFF));
    dir_rows.push_back(smp_row(0, 24'h800000));
    dir_rows.push_back(smp_row(1, 24'h800000, 1'b1, 24'h800000));
    // most negative gain; small negative sum checks truncation toward zero
    dir_rows.push_back(gain_row(1, 1, 16'h8000));
    dir_rows.push_back(smp_row(0, 24'hFFFFFF));
    dir_rows.push_back(smp_row(1, 24'h000000));
    // last lane again without lane 0: reuses the stored lane 0 sample
    dir_rows.push_back(smp_row(1, 24'h123456));
    // zero counts mean one lane each way
    dir_rows.push_back(cfg_row(CFG_IN_COUNT, 4'd0));
    dir_rows.push_back(cfg_row(CFG_OUT_COUNT, 4'd0));
    dir_rows.push_back(smp_row(0, 24'h400000));
    // oversized counts clip to eight lanes
    dir_rows.push_back(cfg_row(CFG_IN_COUNT, 4'd15));
    dir_rows.push_back(cfg_row(CFG_OUT_COUNT, 4'd15));
    dir_rows.push_back(smp_row(0, 24'h7FFFFF));
    dir_rows.push_back(smp_row(1, 24'h800000));
    dir_rows.push_back(smp_row(2, 24'h000001));
    dir_rows.push_back(smp_row(3, 24'hFFFFFF));
    dir_rows.push_back(smp_row(4, 24'h555555));
    dir_rows.push_back(smp_row(5, 24'hAAAAAA));
    dir_rows.push_back(smp_row(6, 24'h0F0F0F));
    dir_rows.push_back(gain_row(7, 7, 16'h1000));
    dir_rows.push_back(smp_row(7, 24'hF0F0F0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
      end else begin
        send_word(dir_rows[i].w, dir_rows[i].known, dir_rows[i].known_mix);
      end
    end

    // -- random phases --
    // every frame-store lane has been written above, so any sample may close a frame
    in_set  = '{8, 1, 0, 15, 0, 3, 0, 5};
    out_set = '{8, 1, 15, 0, 0, 8, 0, 2};
    in_set[4]  = $urandom_range(0, 15);
    out_set[4] = $urandom_range(0, 15);
    in_set[6]  = $urandom_range(0, 15);
    out_set[6] = $urandom_range(0, 15);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      no_idle = (p == 3);
      write_reg(CFG_IN_COUNT, CNT_W'(in_set[p]));
      write_reg(CFG_OUT_COUNT, CNT_W'(out_set[p]));
      // at 8x8 the receiver stalls long enough that results back up into the input
      if (p == 0) hold_left = LONG_HOLD;
      n_in = lane_count(in_cnt_r, MAX_INPUTS);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          send_word(gain_word($urandom_range(0, 7), $urandom_range(0, 7), rand_gain()));
          sent++;
        end else if (pick < 28) begin
          // stray sample on any lane, out of frame order
          send_word(sample_word($urandom_range(0, 7), rand_sample()));
          sent++;
        end else begin
          for (int k = 0; k < n_in; k++) begin
            if ($urandom_range(0, 99) < 15) begin
              send_word(gain_word($urandom_range(0, 7), $urandom_range(0, 7), rand_gain()));
              sent++;
            end
            send_word(sample_word(k, rand_sample()));
            sent++;
          end
        end
      end
    end
    no_idle = 1'b0;

    wait_drained();
    if (mix_due_q.size() != 0) begin
      $error("%0d results never arrived", mix_due_q.size());
      err_cnt++;
    end

    $display("run: %0d words in (%0d gain writes), %0d frames, %0d results checked",
             words_sent, gain_words, frames_cnt, results_ok);
    $display("     %0d register writes over counts 0..15, incl. a long output stall",
             cfg_writes);
    if (err_cnt == 0) begin
      $display("audio_matrix_mixer_top_test: clean");
    end else begin
      $display("audio_matrix_mixer_top_test: errors");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("audio_matrix_mixer_top_test: errors");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/amm_pkg.sv
hdl/amm_ram.sv
hdl/amm_mac.sv
hdl/audio_matrix_mixer_top.sv
hdl/amm_checker.sv
tb/audio_matrix_mixer_top_test.sv
